// ===== hdl/ptme_pkg.sv =====
`timescale 1ns / 1ps
package ptme_pkg;

    // Pool sizing
    localparam int POOL_TABLES_DEF = 16;
    localparam int ENTRIES         = 512;
    localparam int IDX_W           = 9;

    // Descriptor layout
    localparam int          PAGE_SHIFT = 12;
    localparam int          PG_W       = 36;            // page number, bits 47:12
    localparam logic [63:0] DESC_BITS  = 64'h3;

    // Slot reduction: residue fold, then two compare-and-subtract passes
    localparam int             RED_CNT_W = 2;
    localparam logic [RED_CNT_W-1:0] RED_LAST = RED_CNT_W'(2);

    // Configuration registers
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_LIMIT = 1'd1;

    typedef enum logic [1:0] {
        OP_BEGIN = 2'd0,
        OP_MAP   = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] virtual_address;
        logic [47:0] physical_address;
        logic [63:0] attributes;
        logic [3:0]  table_slot;
        logic [8:0]  entry_index;
    } t_in;

    typedef struct packed {
        logic        status;
        logic [63:0] read_word;
    } t_out;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_TAKE,
        ST_CLEAR,
        ST_LINK,
        ST_LOOKUP,
        ST_CHECK,
        ST_REDUCE,
        ST_STEP,
        ST_LEAF,
        ST_FETCH,
        ST_FETCH_WAIT,
        ST_DONE
    } t_state;

    // Controller -> datapath
    typedef struct packed {
        logic load;
        logic take;
        logic clear_step;
        logic link;
        logic reduce_start;
        logic reduce_step;
        logic descend;
        logic leaf;
        logic fetch;
        logic capture;
        logic set_fail;
        logic emit;
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        t_op  op;
        logic root_missing;
        logic pool_full;
        logic clear_last;
        logic entry_valid;
        logic last_level;
        logic reduce_last;
        logic slot_in_pool;
        logic out_free;
    } t_sts;

endpackage

// ===== hdl/page_table_map_engine_core.sv =====
`timescale 1ns / 1ps
// Channel   Handshake                     Payload
// in        i_in_valid / o_in_stall       i_in  (ptme_pkg::t_in)
// out       o_out_valid / i_out_stall     o_out (ptme_pkg::t_out)
// cfg       i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//
// One item at a time. A begin clears one table; a map walks the levels,
// reducing each present entry's descriptor to a pool slot, or taking and
// clearing a new table where the entry is absent. The 512-word clear sweep
// runs through the single store port.
// Reset (synchronous, active low) clears control state; the table store is
// not cleared. A result waits in the output register while the next
// transaction is taken; the block holds the following result until it drains.
module page_table_map_engine_core #(
    parameter int POOL_TABLES = ptme_pkg::POOL_TABLES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  ptme_pkg::t_in                   i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output ptme_pkg::t_out                  o_out,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ptme_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [47:0]                     i_cfg_data
);
    import ptme_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // Registers are always writable
    assign o_cfg_ready = 1'b1;

    ptme_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ptme_dpath #(
        .POOL_TABLES (POOL_TABLES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

endmodule

// ===== hdl/ptme_ram.sv =====
`timescale 1ns / 1ps
module ptme_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/ptme_ctrl.sv =====
`timescale 1ns / 1ps
module ptme_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  ptme_pkg::t_sts  i_sts,
    output ptme_pkg::t_cmd  o_cmd
);
    import ptme_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                unique case (i_sts.op)
                    OP_BEGIN: n_state = ST_TAKE;
                    OP_MAP: begin
                        if (i_sts.root_missing) begin
                            o_cmd.set_fail = 1'b1;
                            n_state        = ST_DONE;
                        end else begin
                            n_state = ST_LOOKUP;
                        end
                    end
                    OP_READ: n_state = i_sts.slot_in_pool ? ST_FETCH : ST_DONE;
                    OP_NONE: n_state = ST_DONE;
                endcase
            end
            ST_TAKE: begin
                if (i_sts.pool_full) begin
                    o_cmd.set_fail = 1'b1;
                    n_state        = ST_DONE;
                end else begin
                    o_cmd.take = 1'b1;
                    n_state    = ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = (i_sts.op == OP_BEGIN) ? ST_DONE : ST_LINK;
                end
            end
            ST_LINK: begin
                // write the table descriptor and step into the new table
                o_cmd.link    = 1'b1;
                o_cmd.descend = 1'b1;
                n_state       = i_sts.last_level ? ST_LEAF : ST_LOOKUP;
            end
            ST_LOOKUP: n_state = ST_CHECK;
            ST_CHECK: begin
                if (i_sts.entry_valid) begin
                    o_cmd.reduce_start = 1'b1;
                    n_state            = ST_REDUCE;
                end else begin
                    n_state = ST_TAKE;
                end
            end
            ST_REDUCE: begin
                o_cmd.reduce_step = 1'b1;
                if (i_sts.reduce_last) begin
                    n_state = ST_STEP;
                end
            end
            ST_STEP: begin
                o_cmd.descend = 1'b1;
                n_state       = i_sts.last_level ? ST_LEAF : ST_LOOKUP;
            end
            ST_LEAF: begin
                o_cmd.leaf = 1'b1;
                n_state    = ST_DONE;
            end
            ST_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = ST_FETCH_WAIT;
            end
            ST_FETCH_WAIT: begin
                o_cmd.capture = 1'b1;
                n_state       = ST_DONE;
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// ===== hdl/ptme_dpath.sv =====
`timescale 1ns / 1ps
module ptme_dpath #(
    parameter int POOL_TABLES = ptme_pkg::POOL_TABLES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ptme_pkg::t_in                       i_in,
    input  logic                                i_cfg_valid,
    input  logic [ptme_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [47:0]                         i_cfg_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output ptme_pkg::t_out                      o_out,
    input  ptme_pkg::t_cmd                      i_cmd,
    output ptme_pkg::t_sts                      o_sts
);
    import ptme_pkg::*;

    // Residues of 2^(4k) modulo POOL_TABLES, one byte per 4-bit chunk
    function automatic logic [8*(PG_W/4)-1:0] chunk_residues();
        logic [8*(PG_W/4)-1:0] res;
        int                    r;
        int                    k;
        int                    b;
        res = '0;
        r   = 1 % POOL_TABLES;
        for (k = 0; k < PG_W / 4; k++) begin
            res[8*k +: 8] = 8'(r);
            for (b = 0; b < 4; b++) begin
                r = (r * 2) % POOL_TABLES;
            end
        end
        return res;
    endfunction

    localparam int ADDR_W = $clog2(POOL_TABLES * ENTRIES);
    localparam int SLOT_W = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
    localparam int U_W    = $clog2(POOL_TABLES + 1);
    localparam int CHUNKS = PG_W / 4;
    localparam int SUM_W  = 16;                      // fold sum < 256 * POOL_TABLES
    localparam logic [31:0]         P32   = 32'(POOL_TABLES);
    localparam logic [8*CHUNKS-1:0] RESID = chunk_residues();

    // Subtract POOL_TABLES << sh when it fits
    function automatic logic [SUM_W-1:0] sub_if_ge(logic [SUM_W-1:0] v, int sh);
        logic [SUM_W-1:0] m;
        m = SUM_W'(POOL_TABLES) << sh;
        return (v >= m) ? v - m : v;
    endfunction

    // Configuration
    logic [PG_W-1:0] r_base;
    logic [4:0]      r_limit;

    // Latched item
    t_op             r_op;
    logic [IDX_W-1:0] r_idx [4];
    logic [PG_W-1:0] r_pa_pg;
    logic [63:0]     r_attr;
    logic [3:0]      r_rd_slot;
    logic [IDX_W-1:0] r_rd_entry;

    // Walk state
    logic [U_W-1:0]    r_used;
    logic [SLOT_W-1:0] r_cur;
    logic [SLOT_W-1:0] r_new;
    logic [1:0]        r_lvl;
    logic [IDX_W-1:0]  r_clr;
    logic [PG_W-1:0]   r_diff;
    logic [SUM_W-1:0]  r_sum;
    logic [SLOT_W-1:0] r_rem;
    logic [RED_CNT_W-1:0] r_red_cnt;
    logic [63:0]       r_word;
    logic              r_fail;
    logic              r_out_valid;
    t_out              r_out;

    // Store port
    logic              w_we;
    logic [ADDR_W-1:0] w_addr;
    logic [63:0]       w_wdata;
    logic [63:0]       w_rdata;
    logic [U_W-1:0]    w_lim;
    logic [PG_W-1:0]   w_desc_pg;
    logic [SUM_W-1:0]  w_fold;
    logic [SUM_W-1:0]  w_sub_hi;
    logic [SUM_W-1:0]  w_sub_lo;
    logic              w_out_free;

    // Limit in force: min(pool_limit, POOL_TABLES)
    assign w_lim = (32'(r_limit) > P32) ? U_W'(POOL_TABLES) : U_W'(r_limit);

    assign w_desc_pg  = r_base + PG_W'(r_new);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Slot reduction: fold 4-bit chunks by their residues, then subtract
    // POOL_TABLES << 7..4 and << 3..0 in two passes
    always_comb begin
        w_fold = '0;
        for (int k = 0; k < CHUNKS; k++) begin
            w_fold = w_fold + SUM_W'(r_diff[4*k +: 4]) * SUM_W'(RESID[8*k +: 8]);
        end
    end

    assign w_sub_hi = sub_if_ge(sub_if_ge(sub_if_ge(sub_if_ge(r_sum, 7), 6), 5), 4);
    assign w_sub_lo = sub_if_ge(sub_if_ge(sub_if_ge(sub_if_ge(r_sum, 3), 2), 1), 0);

    // Store address and write data
    always_comb begin
        w_we    = 1'b0;
        w_addr  = ADDR_W'({r_cur, r_idx[r_lvl]});
        w_wdata = '0;
        if (i_cmd.clear_step) begin
            w_we   = 1'b1;
            w_addr = ADDR_W'({r_new, r_clr});
        end else if (i_cmd.link) begin
            w_we    = 1'b1;
            w_wdata = {16'd0, w_desc_pg, 12'd0} | DESC_BITS;
        end else if (i_cmd.leaf) begin
            w_we    = 1'b1;
            w_wdata = {16'd0, r_pa_pg, 12'd0} | r_attr | DESC_BITS;
        end else if (i_cmd.fetch) begin
            w_addr = ADDR_W'({SLOT_W'(r_rd_slot), r_rd_entry});
        end
    end

    ptme_ram #(
        .WIDTH (64),
        .DEPTH (POOL_TABLES * ENTRIES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_limit <= 5'd16;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_POOL_BASE:  r_base  <= i_cfg_data[47:PAGE_SHIFT];
                REG_POOL_LIMIT: r_limit <= i_cfg_data[4:0];
            endcase
        end
    end

    // Item latch (payload, no reset)
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= t_op'(i_in.operation);
            r_idx[0]   <= i_in.virtual_address[47:39];
            r_idx[1]   <= i_in.virtual_address[38:30];
            r_idx[2]   <= i_in.virtual_address[29:21];
            r_idx[3]   <= i_in.virtual_address[20:12];
            r_pa_pg    <= i_in.physical_address[47:PAGE_SHIFT];
            r_attr     <= i_in.attributes;
            r_rd_slot  <= i_in.table_slot;
            r_rd_entry <= i_in.entry_index;
        end
    end

    // Allocation counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_cmd.load && (t_op'(i_in.operation) == OP_BEGIN)) begin
            r_used <= '0;
        end else if (i_cmd.take) begin
            r_used <= r_used + U_W'(1);
        end
    end

    // Walk, clear sweep and slot reduction
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cur <= '0;
            r_lvl <= '0;
        end else if (i_cmd.descend) begin
            r_cur <= i_cmd.link ? r_new : r_rem;
            r_lvl <= r_lvl + 2'd1;
        end
        if (i_cmd.take) begin
            r_new <= SLOT_W'(r_used);
            r_clr <= '0;
        end else if (i_cmd.clear_step) begin
            r_clr <= r_clr + IDX_W'(1);
        end
        if (i_cmd.reduce_start) begin
            r_diff    <= w_rdata[47:PAGE_SHIFT] - r_base;
            r_red_cnt <= '0;
        end else if (i_cmd.reduce_step) begin
            r_red_cnt <= r_red_cnt + RED_CNT_W'(1);
            if (r_red_cnt == '0) begin
                r_sum <= w_fold;
            end else if (r_red_cnt != RED_LAST) begin
                r_sum <= w_sub_hi;
            end else begin
                r_rem <= SLOT_W'(w_sub_lo);
            end
        end
    end

    // Result word and status
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_word <= '0;
            r_fail <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_word <= w_rdata;
            end
            if (i_cmd.set_fail) begin
                r_fail <= 1'b1;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.status    <= r_fail;
            r_out.read_word <= r_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Status to controller
    always_comb begin
        o_sts.op           = r_op;
        o_sts.root_missing = (r_used == '0);
        o_sts.pool_full    = (r_used >= w_lim);
        o_sts.clear_last   = &r_clr;
        o_sts.entry_valid  = w_rdata[0];
        o_sts.last_level   = (r_lvl == 2'd2);
        o_sts.reduce_last  = (r_red_cnt == RED_LAST);
        o_sts.slot_in_pool = (32'(r_rd_slot) < P32);
        o_sts.out_free     = w_out_free;
    end

endmodule

// ===== hdl/ptme_checker.sv =====
`timescale 1ns / 1ps
module ptme_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input ptme_pkg::t_out                  o_out
);
    import ptme_pkg::*;

    // No result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed");

    // Taking a transaction makes the block busy on the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second transaction taken while busy");

    // A failed begin or map never carries a stored word
    a_fail_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status |-> o_out.read_word == 64'd0)
        else $error("failure status with nonzero word");

endmodule

bind page_table_map_engine_core ptme_checker u_ptme_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

// ===== tb/tb_page_table_map_engine_core.sv =====
`timescale 1ns / 1ps
module tb_page_table_map_engine_core;
    import ptme_pkg::*;

    localparam int          POOL          = POOL_TABLES_DEF;
    localparam int          WORDS         = POOL * ENTRIES;
    localparam logic [47:0] PAGE_MASK     = 48'hffff_ffff_f000;
    localparam logic [63:0] ONES          = '1;
    localparam int          IDLE_LIMIT    = 20000;
    localparam int          RANDOM_PHASES = 8;
    localparam int          PHASE_ITEMS   = 115;
    localparam int          PHASE_LIMITS [RANDOM_PHASES] = '{16, 31, 1, 16, 7, 16, 2, 24};

    // Fixed walks used by the directed part: indices 1/2/3/4 and 9/5/0/0
    localparam logic [63:0] VA_A = {16'h0, 9'd1, 9'd2, 9'd3, 9'd4, 12'h0};
    localparam logic [63:0] VA_X = {16'h0, 9'd9, 9'd5, 9'd0, 9'd0, 12'h0};

    // Mirror of the table pool plus the queue of results still owed by the block
    class ptme_scoreboard;
        logic [63:0] words [WORDS];
        bit          filled [WORDS];
        int          tables_taken;
        logic [47:0] pool_base;
        logic [4:0]  pool_limit;
        t_out        pending_replies [$];
        int          errors;
        int          checked;
        int          begins;
        int          maps;
        int          refused;
        int          reads;

        function new();
            foreach (words[i]) begin
                words[i]  = '0;
                filled[i] = 1'b0;
            end
            tables_taken = 0;
            pool_base    = '0;
            pool_limit   = 5'd16;
            errors       = 0;
            checked      = 0;
            begins       = 0;
            maps         = 0;
            refused      = 0;
            reads        = 0;
        endfunction

        function void load_reg(logic [CFG_IDX_W-1:0] idx, logic [47:0] data);
            if (idx == REG_POOL_BASE) begin
                pool_base = data;
            end else begin
                pool_limit = data[4:0];
            end
        endfunction

        function logic [47:0] base_page();
            return pool_base & PAGE_MASK;
        endfunction

        function int slot_cap();
            return (int'(pool_limit) > POOL) ? POOL : int'(pool_limit);
        endfunction

        function logic [8:0] level_idx(logic [63:0] va, int lvl);
            return va[39 - 9*lvl +: 9];
        endfunction

        function bit is_filled(logic [3:0] slot, logic [8:0] idx);
            return filled[int'(slot)*ENTRIES + int'(idx)];
        endfunction

        // Next free slot, cleared; -1 once the limit is reached
        function int take_slot();
            int slot;
            int i;
            if (tables_taken >= slot_cap()) return -1;
            slot = tables_taken;
            tables_taken++;
            for (i = 0; i < ENTRIES; i++) begin
                words[slot*ENTRIES + i]  = '0;
                filled[slot*ENTRIES + i] = 1'b1;
            end
            return slot;
        endfunction

        function logic [63:0] link_word(int slot);
            logic [47:0] addr;
            addr = (base_page() + (48'(slot) << PAGE_SHIFT)) & PAGE_MASK;
            return {16'h0, addr} | DESC_BITS;
        endfunction

        // Pool slot a descriptor points at, wrapped into the pool
        function int desc_slot(logic [63:0] desc);
            logic [47:0] diff;
            diff = (desc[47:0] & PAGE_MASK) - base_page();
            return int'((diff >> PAGE_SHIFT) % 48'(POOL));
        endfunction

        // True when a map of va touches only entries that were written
        function bit walk_is_clean(logic [63:0] va);
            int cur;
            int pos;
            int lvl;
            if (tables_taken == 0) return 1'b1;
            cur = 0;
            for (lvl = 0; lvl < 3; lvl++) begin
                pos = cur*ENTRIES + int'(level_idx(va, lvl));
                if (!filled[pos]) return 1'b0;
                if (!words[pos][0]) return 1'b1;
                cur = desc_slot(words[pos]);
            end
            return 1'b1;
        endfunction

        // Walk and allocate; returns the status bit
        function logic walk_and_map(t_in it);
            int cur;
            int pos;
            int child;
            int lvl;
            if (tables_taken == 0) return 1'b1;
            cur = 0;
            for (lvl = 0; lvl < 3; lvl++) begin
                pos = cur*ENTRIES + int'(level_idx(it.virtual_address, lvl));
                if (!words[pos][0]) begin
                    child = take_slot();
                    if (child < 0) return 1'b1;
                    words[pos] = link_word(child);
                end
                cur = desc_slot(words[pos]);
            end
            pos = cur*ENTRIES + int'(level_idx(it.virtual_address, 3));
            words[pos]  = {16'h0, it.physical_address & PAGE_MASK} | it.attributes | DESC_BITS;
            filled[pos] = 1'b1;
            return 1'b0;
        endfunction

        function t_out update_tables(t_in it);
            t_out res;
            res = '0;
            case (t_op'(it.operation))
                OP_BEGIN: begin
                    tables_taken = 0;
                    res.status = (take_slot() < 0);
                    begins++;
                end
                OP_MAP: begin
                    res.status = walk_and_map(it);
                    maps++;
                    if (res.status) refused++;
                end
                OP_READ: begin
                    if (int'(it.table_slot) < POOL)
                        res.read_word = words[int'(it.table_slot)*ENTRIES + int'(it.entry_index)];
                    reads++;
                end
                default: ;
            endcase
            return res;
        endfunction

        function void note_input(t_in it);
            pending_replies.push_back(update_tables(it));
        endfunction

        function void check_result(t_out got);
            t_out want;
            checked++;
            if (pending_replies.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, status %0d word %h",
                         $time, got.status, got.read_word);
                return;
            end
            want = pending_replies.pop_front();
            if (got.status !== want.status) begin
                errors++;
                $display("%0t: status mismatch, expected %0d actual %0d",
                         $time, want.status, got.status);
            end
            if (got.read_word !== want.read_word) begin
                errors++;
                $display("%0t: read_word mismatch, expected %h actual %h",
                         $time, want.read_word, got.read_word);
            end
        endfunction
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in                  i_in        = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out                 o_out;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = REG_POOL_BASE;
    logic [47:0]          i_cfg_data  = '0;

    ptme_scoreboard sb;
    logic [63:0]    last_va     = '0;
    bit             burst       = 1'b0;
    int             items_sent  = 0;
    int             reg_writes  = 0;
    int             idle_cycles = 0;

    page_table_map_engine_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Watchdog: cycles without any transaction on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog, no transaction for %0d cycles", $time, idle_cycles);
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic t_in make_item(t_op op, logic [63:0] va, logic [47:0] pa,
                                      logic [63:0] attrs, logic [3:0] slot, logic [8:0] idx);
        t_in it;
        it.operation        = op;
        it.virtual_address  = va;
        it.physical_address = pa;
        it.attributes       = attrs;
        it.table_slot       = slot;
        it.entry_index      = idx;
        return it;
    endfunction

    function automatic int next_gap();
        int r;
        if (burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(15, 150);
    endfunction

    // Level index biased toward a few values so walks share tables
    function automatic logic [8:0] pick_index();
        case ($urandom_range(0, 4))
            0: return 9'd0;
            1: return 9'h1ff;
            2, 3: return 9'($urandom_range(0, 3));
            default: return 9'($urandom);
        endcase
    endfunction

    function automatic t_in random_item();
        t_in it;
        int  pick;
        int  tries;
        int  lvl;
        it.operation        = OP_NONE;
        it.virtual_address  = {$urandom, $urandom};
        it.physical_address = 48'({$urandom, $urandom});
        it.attributes       = ($urandom_range(0, 3) == 0) ? 64'h0 : {$urandom, $urandom};
        it.table_slot       = 4'($urandom);
        it.entry_index      = 9'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            it.operation = OP_BEGIN;
        end else if (pick < 60) begin
            for (lvl = 0; lvl < 4; lvl++)
                if ($urandom_range(0, 3) != 0)
                    it.virtual_address[39 - 9*lvl +: 9] = pick_index();
            // A walk through stale descriptors could land on unwritten entries
            if (sb.walk_is_clean(it.virtual_address)) begin
                it.operation = OP_MAP;
                last_va      = it.virtual_address;
            end
        end else if (pick < 95) begin
            for (tries = 0; tries < 8 && it.operation == OP_NONE; tries++) begin
                if ($urandom_range(0, 1)) it.table_slot = 4'($urandom_range(0, 3));
                else it.table_slot = 4'($urandom);
                if ($urandom_range(0, 2) != 0) begin
                    lvl = $urandom_range(0, 3);
                    it.entry_index = last_va[39 - 9*lvl +: 9];
                end else begin
                    it.entry_index = 9'($urandom);
                end
                if (sb.is_filled(it.table_slot, it.entry_index)) it.operation = OP_READ;
            end
        end
        return it;
    endfunction

    // One input transaction; called and returning at a rising edge
    task automatic send_item(t_in it, int gap);
        i_in       <= it;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(it);
        items_sent++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending_replies.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Register write, only with the block idle
    task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [47:0] data);
        drain();
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.load_reg(idx, data);
        reg_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    // Result side: random stall runs, one long hold-off to fill the block
    initial begin : result_side
        int   roll;
        int   span;
        logic hold;
        bit   pressed;
        pressed = 1'b0;
        @(posedge i_clk);
        forever begin
            roll = $urandom_range(0, 99);
            if (!pressed && sb.checked >= 150) begin
                hold    = 1'b1;
                span    = 3000;
                pressed = 1'b1;
            end else if (roll < 50) begin
                hold = 1'b0;
                span = $urandom_range(1, 40);
            end else if (roll < 92) begin
                hold = 1'b1;
                span = $urandom_range(1, 4);
            end else begin
                hold = 1'b1;
                span = $urandom_range(15, 150);
            end
            repeat (span) begin
                i_out_stall <= hold;
                @(posedge i_clk);
                if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out);
            end
        end
    end

    initial begin : stimulus
        int          phase;
        int          n;
        logic [47:0] base;
        int          lim;
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // No root yet, then the unused operation code with every field set
        send_item(make_item(OP_MAP, ONES, '1, ONES, 4'hf, 9'h1ff), next_gap());
        send_item(make_item(OP_NONE, ONES, '1, ONES, 4'hf, 9'h1ff), next_gap());

        // Zero limit: begin takes no root and the map is refused
        program_reg(REG_POOL_LIMIT, 48'd0);
        send_item(make_item(OP_BEGIN, '0, '0, '0, '0, '0), next_gap());
        send_item(make_item(OP_MAP, VA_A, 48'h1000, '0, '0, '0), next_gap());

        // Full pool at base zero: extreme walks, reuse of a path, reads back
        program_reg(REG_POOL_BASE, 48'd0);
        program_reg(REG_POOL_LIMIT, 48'd16);
        send_item(make_item(OP_BEGIN, ONES, '1, ONES, 4'hf, 9'h1ff), next_gap());
        send_item(make_item(OP_MAP, ONES, '1, ONES, 4'hf, 9'h1ff), next_gap());
        send_item(make_item(OP_MAP, '0, '0, '0, '0, '0), next_gap());
        send_item(make_item(OP_READ, ONES, '1, ONES, 4'd0, 9'h1ff), next_gap());
        send_item(make_item(OP_READ, '0, '0, '0, 4'd3, 9'h1ff), next_gap());
        send_item(make_item(OP_READ, '0, '0, '0, 4'd6, 9'd0), next_gap());
        send_item(make_item(OP_MAP, ONES, 48'h1234_5678_9abc, '0, '0, '0), next_gap());
        send_item(make_item(OP_READ, '0, '0, '0, 4'd3, 9'h1ff), next_gap());
        send_item(make_item(OP_MAP, VA_A, 48'h0000_dead_b000, 64'h0040_0000_0000_0700,
                            '0, '0), next_gap());
        send_item(make_item(OP_READ, '0, '0, '0, 4'd0, 9'd1), next_gap());

        // Pool runs out in the middle of a walk; the first descriptor stays
        program_reg(REG_POOL_LIMIT, 48'd2);
        send_item(make_item(OP_BEGIN, '0, '0, '0, '0, '0), next_gap());
        send_item(make_item(OP_MAP, VA_X, 48'h5000, '0, '0, '0), next_gap());
        send_item(make_item(OP_READ, '0, '0, '0, 4'd0, 9'd9), next_gap());
        send_item(make_item(OP_READ, '0, '0, '0, 4'd1, 9'd5), next_gap());

        // Base moved below the built tables: old descriptors land on other slots
        program_reg(REG_POOL_LIMIT, 48'd16);
        send_item(make_item(OP_BEGIN, '0, '0, '0, '0, '0), next_gap());
        send_item(make_item(OP_MAP, VA_A, 48'h7000, '0, '0, '0), next_gap());
        program_reg(REG_POOL_BASE, 48'hffff_ffff_eabc);
        send_item(make_item(OP_MAP, VA_A, 48'h8000, 64'h1, '0, '0), next_gap());
        send_item(make_item(OP_READ, '0, '0, '0, 4'd3, 9'd2), next_gap());
        send_item(make_item(OP_READ, '0, '0, '0, 4'd5, 9'd4), next_gap());

        // Highest base: the first child descriptor wraps to address zero
        program_reg(REG_POOL_BASE, 48'hffff_ffff_ffff);
        send_item(make_item(OP_BEGIN, '0, '0, '0, '0, '0), next_gap());
        send_item(make_item(OP_MAP, ONES, '0, 64'h8000_0000_0000_0000, '0, '0), next_gap());
        send_item(make_item(OP_READ, '0, '0, '0, 4'd0, 9'h1ff), next_gap());

        // Random phases, each with its own base and limit
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: base = 48'd0;
                1: base = 48'hffff_ffff_ffff;
                default: base = 48'({$urandom, $urandom});
            endcase
            lim = (phase == 4) ? $urandom_range(0, 31) : PHASE_LIMITS[phase];
            program_reg(REG_POOL_BASE, base);
            program_reg(REG_POOL_LIMIT, 48'(lim));
            burst = (phase % 4 == 3);
            // Some phases keep the old tables under the new base
            if (phase % 3 != 2)
                send_item(make_item(OP_BEGIN, {$urandom, $urandom}, 48'({$urandom, $urandom}),
                                    {$urandom, $urandom}, 4'($urandom), 9'($urandom)),
                          next_gap());
            for (n = 0; n < PHASE_ITEMS; n++) send_item(random_item(), next_gap());
        end
        burst = 1'b0;

        drain();
        repeat (20) @(posedge i_clk);
        $display("Covered %0d transactions: %0d begin, %0d map (%0d refused), %0d read.",
                 items_sent, sb.begins, sb.maps, sb.refused, sb.reads);
        $display("%0d results checked over %0d register writes, %0d mismatches.",
                 sb.checked, reg_writes, sb.errors);
        if (sb.errors == 0 && sb.pending_replies.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
